// ===== sv/mrre_pkg.sv =====
package mrre_pkg;

	localparam logic [2:0] FN_SEND    = 3'd0;
	localparam logic [2:0] FN_RECV    = 3'd1;
	localparam logic [2:0] FN_REPLY   = 3'd2;
	localparam logic [2:0] FN_POLL    = 3'd3;
	localparam logic [2:0] FN_CLEANUP = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NOIPC   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	// Datapath operations requested by the controller.
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LATCH    = 4'd1;
	localparam logic [3:0] OP_RD_HEAD  = 4'd2;
	localparam logic [3:0] OP_POP      = 4'd3;
	localparam logic [3:0] OP_RD_SCAN  = 4'd4;
	localparam logic [3:0] OP_CHK_SCAN = 4'd5;
	localparam logic [3:0] OP_PUSH     = 4'd6;
	localparam logic [3:0] OP_CLR_TAG  = 4'd7;
	localparam logic [3:0] OP_DRAIN    = 4'd8;
	localparam logic [3:0] OP_STATUS   = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] st;
	} mrre_cmd_t;

	typedef struct packed {
		logic       found;
		logic       tag_nz;
		logic       client_ok;
		logic       client_full;
		logic       scan_last;
		logic [2:0] pre_st;
	} mrre_stat_t;

endpackage

// ===== sv/mrre_ram.sv =====
module mrre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/mrre_datapath.sv =====
module mrre_datapath #(
	parameter int NUM_TASKS   = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrre_pkg::mrre_cmd_t  cmd,
	output mrre_pkg::mrre_stat_t stat,
	input  logic [2:0]           func,
	input  logic [2:0]           caller,
	input  logic [2:0]           target,
	input  logic                 target_dead,
	input  logic [15:0]          reply_tag,
	input  logic [31:0]          payload,
	output logic [2:0]           status,
	output logic                 msg_valid,
	output logic [2:0]           msg_sender,
	output logic [15:0]          msg_tag,
	output logic [31:0]          msg_data,
	output logic                 pending
);
	import mrre_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = NUM_TASKS * QUEUE_DEPTH;
	localparam int AW = $clog2(SLOTS);
	localparam int MW = 3 + 16 + DATA_WIDTH;

	logic [2:0]            func_q, caller_q, target_q;
	logic                  dead_q;
	logic [15:0]           rtag_q, tagc_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [PW-1:0]         head_q [NUM_TASKS];
	logic [PW-1:0]         tail_q [NUM_TASKS];
	logic [CW-1:0]         fill_q [NUM_TASKS];
	logic [SLOTS-1:0]      mvalid_q, tvalid_q;
	logic [PW-1:0]         idx_q;
	logic [AW-1:0]         found_q;
	logic                  found_ok_q;
	logic [15:0]           scan_tag_q;
	logic [2:0]            scan_snd_q;

	logic [TW-1:0] cal_i, tgt_i;
	logic caller_ok, target_ok;
	assign caller_ok = {5'd0, caller_q} < 8'(NUM_TASKS);
	assign target_ok = {5'd0, target_q} < 8'(NUM_TASKS);
	assign cal_i = TW'(caller_q);
	assign tgt_i = TW'(target_q);

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return ({1'b0, p} + 1'b1 >= (PW+1)'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
	endfunction

	// Push destination, sender and content depend on the operation.
	logic          is_cleanup;
	logic [TW-1:0] pbox;
	logic [2:0]    psnd;
	logic [15:0]   ptag, newtag;
	logic [DATA_WIDTH-1:0] pdata;
	assign is_cleanup = func_q == FN_CLEANUP;
	assign newtag = (tagc_q + 16'd1 == 16'd0) ? 16'd1 : tagc_q + 16'd1;
	always_comb begin
		if (is_cleanup) begin
			pbox = TW'(scan_snd_q); psnd = target_q; ptag = scan_tag_q;
			pdata = DATA_WIDTH'(ST_NOIPC);
		end else if (func_q == FN_SEND) begin
			pbox = tgt_i; psnd = caller_q; ptag = newtag; pdata = data_q;
		end else begin
			pbox = tgt_i; psnd = caller_q; ptag = rtag_q; pdata = data_q;
		end
	end

	// Message and tag memories.
	logic          m_we, t_we;
	logic [AW-1:0] m_wa, t_wa, m_ra, t_ra;
	logic [MW-1:0] m_wd, m_rd;
	logic [15:0]   t_wd, t_rd;
	logic [AW-1:0] push_a, scan_a, head_a;
	assign push_a = AW'(pbox) * AW'(QUEUE_DEPTH) + AW'(tail_q[pbox]);
	assign scan_a = (is_cleanup ? AW'(tgt_i) : AW'(cal_i)) * AW'(QUEUE_DEPTH) + AW'(idx_q);
	assign head_a = AW'(cal_i) * AW'(QUEUE_DEPTH) + AW'(head_q[cal_i]);

	always_comb begin
		m_we = 1'b0; t_we = 1'b0;
		m_wa = push_a; m_wd = {psnd, ptag, pdata};
		t_wa = push_a; t_wd = newtag;
		m_ra = scan_a; t_ra = scan_a;
		if (cmd.op == OP_RD_HEAD) m_ra = head_a;
		if (cmd.op == OP_PUSH) begin
			m_we = 1'b1;
			t_we = func_q == FN_SEND;
		end
		if (cmd.op == OP_CLR_TAG) begin
			t_we = 1'b1; t_wd = 16'd0;
			t_wa = is_cleanup ? scan_a : found_q;
		end
	end

	mrre_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_msg (
		.clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	mrre_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_tag (
		.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

	// Read address is kept so valid bits can mask never-written entries.
	logic [AW-1:0] ra_q;
	logic [MW-1:0] m_eff;
	logic [15:0]   t_eff;
	assign m_eff = mvalid_q[ra_q] ? m_rd : '0;
	assign t_eff = tvalid_q[ra_q] ? t_rd : '0;

	// Status computed from the latched command before any memory access.
	logic full_t, full_c;
	logic [2:0] pre_st;
	assign full_t = fill_q[tgt_i] >= CW'(QUEUE_DEPTH);
	assign full_c = fill_q[TW'(scan_snd_q)] >= CW'(QUEUE_DEPTH);
	always_comb begin
		pre_st = ST_OK;
		if (func_q <= FN_POLL && !caller_ok) pre_st = ST_INVALID;
		else unique case (func_q)
			FN_SEND: begin
				if (!target_ok || target_q == caller_q) pre_st = ST_INVALID;
				else if (dead_q) pre_st = ST_NOIPC;
				else if (full_t) pre_st = ST_FULL;
			end
			FN_RECV: if (fill_q[cal_i] == '0) pre_st = ST_EMPTY;
			FN_REPLY: begin
				if (!target_ok || target_q == caller_q || rtag_q == 16'd0)
					pre_st = ST_INVALID;
				else if (dead_q) pre_st = ST_NOIPC;
			end
			FN_POLL: pre_st = ST_OK;
			FN_CLEANUP: if (!target_ok) pre_st = ST_INVALID;
			default: pre_st = ST_INVALID;
		endcase
	end
	assign stat.pre_st = pre_st;
	assign stat.found = found_ok_q;
	assign stat.tag_nz = t_eff != 16'd0;
	assign stat.client_ok = {5'd0, m_eff[MW-1 -: 3]} < 8'(NUM_TASKS);
	assign stat.client_full = is_cleanup ? full_c : full_t;
	assign stat.scan_last = {1'b0, idx_q} == (PW+1)'(QUEUE_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tagc_q <= '0; mvalid_q <= '0; tvalid_q <= '0;
			idx_q <= '0; found_ok_q <= 1'b0; msg_valid <= 1'b0;
			status <= ST_OK; msg_sender <= '0; msg_tag <= '0; msg_data <= '0;
			pending <= 1'b0; ra_q <= '0;
			func_q <= '0; caller_q <= '0; target_q <= '0; dead_q <= 1'b0;
			rtag_q <= '0; data_q <= '0; found_q <= '0;
			scan_tag_q <= '0; scan_snd_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				head_q[i] <= '0; tail_q[i] <= '0; fill_q[i] <= '0;
			end
		end else begin
			ra_q <= m_ra;
			if (m_we) mvalid_q[m_wa] <= 1'b1;
			if (t_we) tvalid_q[t_wa] <= 1'b1;
			unique case (cmd.op)
				OP_LATCH: begin
					func_q <= func; caller_q <= caller; target_q <= target;
					dead_q <= target_dead; rtag_q <= reply_tag;
					data_q <= DATA_WIDTH'(payload);
					idx_q <= '0; found_ok_q <= 1'b0;
					msg_valid <= 1'b0; pending <= 1'b0;
					msg_sender <= '0; msg_tag <= '0; msg_data <= '0;
				end
				OP_POP: begin
					msg_sender <= m_eff[MW-1 -: 3];
					msg_tag <= m_eff[DATA_WIDTH +: 16];
					msg_data <= 32'(m_eff[DATA_WIDTH-1:0]);
					msg_valid <= 1'b1;
					head_q[cal_i] <= nxt(head_q[cal_i]);
					fill_q[cal_i] <= fill_q[cal_i] - 1'b1;
				end
				OP_CHK_SCAN: begin
					if (!is_cleanup && !found_ok_q && t_eff == rtag_q) begin
						found_ok_q <= 1'b1; found_q <= ra_q;
					end
					scan_tag_q <= t_eff;
					scan_snd_q <= m_eff[MW-1 -: 3];
				end
				OP_PUSH: begin
					if (func_q == FN_SEND) tagc_q <= tagc_q + 16'd1;
					tail_q[pbox] <= nxt(tail_q[pbox]);
					fill_q[pbox] <= fill_q[pbox] + 1'b1;
				end
				OP_CLR_TAG: if (is_cleanup) idx_q <= idx_q + 1'b1;
				OP_RD_SCAN: ;
				OP_DRAIN: begin
					head_q[tgt_i] <= tail_q[tgt_i];
					fill_q[tgt_i] <= '0;
				end
				OP_STATUS: begin
					status <= cmd.st;
					pending <= func_q == FN_POLL && cmd.st == ST_OK && fill_q[cal_i] != '0;
				end
				OP_NONE: begin
					msg_valid <= 1'b0; pending <= 1'b0;
					msg_sender <= '0; msg_tag <= '0; msg_data <= '0;
				end
				default: ;
			endcase
			if (cmd.op == OP_RD_SCAN && !is_cleanup) idx_q <= idx_q;
			if (cmd.op == OP_CHK_SCAN && !is_cleanup && !stat.scan_last)
				idx_q <= idx_q + 1'b1;
		end
	end
endmodule

// ===== sv/mrre_ctrl.sv =====
module mrre_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic [2:0]           func,
	output mrre_pkg::mrre_cmd_t  cmd,
	input  mrre_pkg::mrre_stat_t stat
);
	import mrre_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RHEAD = 4'd2, S_POP = 4'd3,
		S_RSCAN = 4'd4, S_CHK = 4'd5, S_RCHK = 4'd6, S_PUSH = 4'd7, S_CLR = 4'd8,
		S_DRAIN = 4'd9, S_DONE = 4'd10, S_CPUSH = 4'd11;

	logic [3:0] state_q, state_d;
	logic [2:0] st_q, st_d;
	logic [2:0] func_q;
	logic       last_q;

	always_comb begin
		state_d = state_q; st_d = st_q;
		cmd.op = OP_NONE; cmd.st = st_q;
		unique case (state_q)
			S_IDLE: if (start) begin cmd.op = OP_LATCH; state_d = S_DEC; end
			S_DEC: begin
				cmd.op = OP_RD_SCAN;
				st_d = stat.pre_st;
				if (stat.pre_st != ST_OK) state_d = S_DONE;
				else unique case (func_q)
					FN_SEND: state_d = S_PUSH;
					FN_RECV: state_d = S_RHEAD;
					FN_REPLY, FN_CLEANUP: state_d = S_RSCAN;
					default: state_d = S_DONE;
				endcase
			end
			S_RHEAD: begin cmd.op = OP_RD_HEAD; state_d = S_POP; end
			S_POP: begin cmd.op = OP_POP; state_d = S_DONE; end
			S_RSCAN: begin cmd.op = OP_RD_SCAN; state_d = S_CHK; end
			S_CHK: begin
				cmd.op = OP_CHK_SCAN;
				if (func_q == FN_CLEANUP) state_d = S_CLR;
				else if (stat.scan_last) state_d = S_RCHK;
				else state_d = S_RSCAN;
			end
			S_RCHK: begin
				if (!stat.found) begin st_d = ST_INVALID; state_d = S_DONE; end
				else if (stat.client_full) begin st_d = ST_FULL; state_d = S_DONE; end
				else begin cmd.op = OP_CLR_TAG; state_d = S_PUSH; end
			end
			S_PUSH: begin cmd.op = OP_PUSH; state_d = S_DONE; end
			S_CLR: begin
				// The tag memory still shows this slot; the scan index moves on here.
				if (stat.tag_nz) begin
					cmd.op = OP_CLR_TAG;
					state_d = S_CPUSH;
				end else begin
					cmd.op = OP_CLR_TAG;
					state_d = stat.scan_last ? S_DRAIN : S_RSCAN;
				end
			end
			S_CPUSH: begin
				if (stat.client_ok && !stat.client_full) cmd.op = OP_PUSH;
				state_d = last_q ? S_DRAIN : S_RSCAN;
			end
			S_DRAIN: begin cmd.op = OP_DRAIN; state_d = S_DONE; end
			S_DONE: begin cmd.op = OP_STATUS; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; st_q <= ST_OK; func_q <= '0; done <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d; st_q <= st_d;
			done <= state_q == S_DONE;
			if (state_q == S_IDLE && start) func_q <= func;
			if (state_q == S_CLR) last_q <= stat.scan_last;
		end
	end
	assign busy = state_q != S_IDLE;
endmodule

// ===== sv/mailbox_request_reply_engine.sv =====
// Mailbox request/reply engine: a start pulse while busy is low transfers one command
// (send, receive, reply, poll or cleanup); one result follows with the done strobe held
// for a single cycle, and the receiver cannot stall it. Reply scans all QUEUE_DEPTH tag
// slots of the caller's mailbox one at a time, reading each slot and then checking it;
// cleanup reads, checks and clears the tag of each slot of the target's mailbox, queues
// an error message to the sender of each slot that held a tag when its mailbox has room,
// and then drains the target's mailbox. The scans are paced by the single read port of
// the message and tag memories.
module mailbox_request_reply_engine #(
	parameter int NUM_TASKS   = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  func,
	input  logic [2:0]  caller,
	input  logic [2:0]  target,
	input  logic        target_dead,
	input  logic [15:0] reply_tag,
	input  logic [31:0] payload,
	output logic [2:0]  status,
	output logic        msg_valid,
	output logic [2:0]  msg_sender,
	output logic [15:0] msg_tag,
	output logic [31:0] msg_data,
	output logic        pending
);
	import mrre_pkg::*;

	mrre_cmd_t  cmd;
	mrre_stat_t stat;

	// The controller sequences; the datapath owns all mailbox state.
	mrre_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .done, .func, .cmd, .stat);

	mrre_datapath #(.NUM_TASKS(NUM_TASKS), .QUEUE_DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .func, .caller, .target, .target_dead,
		.reply_tag, .payload, .status, .msg_valid, .msg_sender, .msg_tag,
		.msg_data, .pending);

	// A result strobe is never followed directly by another.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// A delivered message always reports status ok.
	a_msg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && msg_valid |-> status == ST_OK) else $error("msg with bad status");
	// Results appear only after a command was in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
endmodule
